/* sv/point_rotate_about_pivot_macros.svh */
// ---------------------------------------------------------------------------
// Point rotation assertion macros
// Shared assertion forms for the point rotation block. They expect signals
// named clk and rst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef POINT_ROTATE_ABOUT_PIVOT_MACROS_SVH
`define POINT_ROTATE_ABOUT_PIVOT_MACROS_SVH

// Checked on every rising edge outside reset.
`define PRAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PRAP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/prap_pkg.sv */
// ---------------------------------------------------------------------------
// Point rotation package
// Field widths, angle constants, CORDIC widths and the arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none

package prap_pkg;

    localparam int ANGLE_W   = 14;   // angle field, 1/16 degree
    localparam int OUT_W     = 14;   // rotated coordinate fields
    localparam int ANG_RED_W = 13;   // reduced angle, 0 to 5759
    localparam int REM_W     = 11;   // remainder angle, -720 to 719

    localparam int ANG_FULL    = 5760;
    localparam int ANG_QUARTER = 1440;
    localparam int ANG_EIGHTH  = 720;

    localparam int X_W       = 33;   // CORDIC x and y, Q30
    localparam int Z_W       = 28;   // CORDIC angle, 1/16 degree scaled by 2^16
    localparam int ZFRAC_W   = 16;
    localparam int CS_W      = 17;   // cosine and sine, Q1.15 with +-1.0
    localparam int Q15       = 15;

    localparam int ONE_Q15         = 32768;
    localparam int ROUND_HALF_Q15  = 16384;
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int OUT_MIN         = -8192;
    localparam int OUT_MAX         = 8191;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // atan(2^-i) in the CORDIC angle unit.
    function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
        logic signed [Z_W-1:0] val;
        unique case (idx)
            0:  val = 28'sd47185920;
            1:  val = 28'sd27855475;
            2:  val = 28'sd14718068;
            3:  val = 28'sd7471121;
            4:  val = 28'sd3750058;
            5:  val = 28'sd1876857;
            6:  val = 28'sd938658;
            7:  val = 28'sd469357;
            8:  val = 28'sd234682;
            9:  val = 28'sd117342;
            10: val = 28'sd58671;
            11: val = 28'sd29335;
            12: val = 28'sd14668;
            13: val = 28'sd7334;
            14: val = 28'sd3667;
            15: val = 28'sd1833;
            16: val = 28'sd917;
            17: val = 28'sd458;
            18: val = 28'sd229;
            19: val = 28'sd115;
            20: val = 28'sd57;
            21: val = 28'sd29;
            22: val = 28'sd14;
            23: val = 28'sd7;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* sv/prap_if.sv */
// ---------------------------------------------------------------------------
// Point rotation channels
// Valid/ready channels for the request item (point, pivot, angle) and the
// result item (rotated point).
// ---------------------------------------------------------------------------
`default_nettype none

interface prap_req_if
    import prap_pkg::*;
#(
    parameter int COORD_WIDTH = 12
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] pivot_x;
    logic signed [COORD_WIDTH-1:0] pivot_y;
    logic signed [ANGLE_W-1:0]     angle;

    modport source (
        output valid, point_x, point_y, pivot_x, pivot_y, angle,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, pivot_x, pivot_y, angle,
        output ready
    );
endinterface

interface prap_rsp_if
    import prap_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] rotated_x;
    logic signed [OUT_W-1:0] rotated_y;

    modport source (
        output valid, rotated_x, rotated_y,
        input  ready
    );
    modport sink (
        input  valid, rotated_x, rotated_y,
        output ready
    );
endinterface

`default_nettype wire

/* sv/point_rotate_about_pivot.sv */
// ---------------------------------------------------------------------------
// Point rotation about a pivot
// Takes one item per clock while the result side is not stalled. Most of the
// pipeline is the CORDIC, which has one register stage per iteration; the
// other stages reduce the angle, split it into a quarter turn and a
// remainder, round the cosine and sine, form the four products, add them to
// the pivot, and truncate and saturate. Results are exact to the Q1.15
// cosine and sine and truncated toward zero. The whole pipeline advances
// whenever the output register is empty or its item is being taken, so a
// stalled result holds every stage in place and nothing is dropped or
// repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module point_rotate_about_pivot
    import prap_pkg::*;
#(
    parameter int COORD_WIDTH     = 12,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    prap_req_if.sink   req,
    prap_rsp_if.source rsp
);

    localparam int DW = COORD_WIDTH + 1;   // point minus pivot
    localparam int PW = DW + CS_W;         // one product
    localparam int SW = PW + 2;            // pivot plus two products
    localparam int TW = SW - Q15;          // truncated sum
    localparam int N  = TRIG_ITERATIONS;

    typedef struct packed {
        logic signed [DW-1:0]          dx;
        logic signed [DW-1:0]          dy;
        logic signed [COORD_WIDTH-1:0] qx;
        logic signed [COORD_WIDTH-1:0] qy;
    } geo_t;

    typedef struct packed {
        geo_t       geo;
        logic [1:0] quad;
        logic       rem_zero;
    } side_t;

    function automatic logic signed [CS_W-1:0] round_q15(
        input logic signed [X_W-1:0] v
    );
        logic signed [X_W-1:0] t;
        logic signed [CS_W-1:0] r;
        t = (v + X_W'(ROUND_HALF_Q15)) >>> Q15;
        if (t > ONE_Q15) begin
            r = CS_W'(ONE_Q15);
        end else if (t < -ONE_Q15) begin
            r = CS_W'(-ONE_Q15);
        end else begin
            r = CS_W'(t);
        end
        return r;
    endfunction

    // Truncates toward zero, then saturates to the output range.
    function automatic logic signed [OUT_W-1:0] finish(
        input logic signed [SW-1:0] v
    );
        logic signed [SW-1:0] adj;
        logic signed [TW-1:0] t;
        logic signed [OUT_W-1:0] r;
        adj = v[SW-1] ? v + SW'(ONE_Q15 - 1) : v;
        t = TW'(adj >>> Q15);
        if (t > OUT_MAX) begin
            r = OUT_W'(OUT_MAX);
        end else if (t < OUT_MIN) begin
            r = OUT_W'(OUT_MIN);
        end else begin
            r = OUT_W'(t);
        end
        return r;
    endfunction

    logic adv;

    // Stage 0: angle reduced to one turn, point offset from the pivot.
    logic                      s0_v_reg;
    logic [ANG_RED_W-1:0]      s0_ang_reg;
    geo_t                      s0_geo_reg;
    logic signed [ANGLE_W:0]   ang_ext;
    logic signed [ANGLE_W:0]   ang_mod;
    logic [ANG_RED_W-1:0]      s0_ang_next;
    geo_t                      s0_geo_next;

    // CORDIC stages: index 0 holds the start values, index i+1 the result of
    // iteration i.
    logic                    cv_reg [0:N];
    logic signed [X_W-1:0]   cx_reg [0:N];
    logic signed [X_W-1:0]   cy_reg [0:N];
    logic signed [Z_W-1:0]   cz_reg [0:N];
    side_t                   cside_reg [0:N];

    logic signed [ANG_RED_W:0] ang_s;
    logic signed [ANG_RED_W:0] rem_wide;
    logic signed [REM_W-1:0]   rem;
    logic [1:0]                quad_next;
    side_t                     cside_next;

    // Cosine and sine stage.
    logic                    cs_v_reg;
    logic signed [CS_W-1:0]  cs_c_reg;
    logic signed [CS_W-1:0]  cs_s_reg;
    geo_t                    cs_geo_reg;
    logic signed [CS_W-1:0]  c0;
    logic signed [CS_W-1:0]  s0;
    logic signed [CS_W-1:0]  cs_c_next;
    logic signed [CS_W-1:0]  cs_s_next;

    // Product stage.
    logic                          m_v_reg;
    logic signed [PW-1:0]          m_xc_reg;
    logic signed [PW-1:0]          m_ys_reg;
    logic signed [PW-1:0]          m_xs_reg;
    logic signed [PW-1:0]          m_yc_reg;
    logic signed [COORD_WIDTH-1:0] m_qx_reg;
    logic signed [COORD_WIDTH-1:0] m_qy_reg;

    // Sum stage.
    logic                 sm_v_reg;
    logic signed [SW-1:0] sm_x_reg;
    logic signed [SW-1:0] sm_y_reg;
    logic signed [SW-1:0] sm_x_next;
    logic signed [SW-1:0] sm_y_next;

    // Output register.
    logic                    rv_reg;
    logic signed [OUT_W-1:0] rx_reg;
    logic signed [OUT_W-1:0] ry_reg;

    assign adv       = !rv_reg || rsp.ready;
    assign req.ready = adv;

    // ---- stage 0 ----
    assign ang_ext = {req.angle[ANGLE_W-1], req.angle};

    always_comb begin
        priority if (ang_ext < -ANG_FULL) begin
            ang_mod = (ANGLE_W+1)'(ang_ext + 2 * ANG_FULL);
        end else if (ang_ext < 0) begin
            ang_mod = (ANGLE_W+1)'(ang_ext + ANG_FULL);
        end else if (ang_ext >= ANG_FULL) begin
            ang_mod = (ANGLE_W+1)'(ang_ext - ANG_FULL);
        end else begin
            ang_mod = ang_ext;
        end
    end

    assign s0_ang_next    = ang_mod[ANG_RED_W-1:0];
    assign s0_geo_next.dx = DW'(req.point_x) - DW'(req.pivot_x);
    assign s0_geo_next.dy = DW'(req.point_y) - DW'(req.pivot_y);
    assign s0_geo_next.qx = req.pivot_x;
    assign s0_geo_next.qy = req.pivot_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_v_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_ang_reg <= s0_ang_next;
            s0_geo_reg <= s0_geo_next;
        end
    end

    // ---- quarter turn split and CORDIC start ----
    assign ang_s = signed'({1'b0, s0_ang_reg});

    // The remainder lies in [-45, 45) degrees; a full turn folds to quadrant 0.
    always_comb begin
        priority if (ang_s < ANG_EIGHTH) begin
            quad_next = QUAD_0;
            rem_wide  = ang_s;
        end else if (ang_s < ANG_EIGHTH + ANG_QUARTER) begin
            quad_next = QUAD_1;
            rem_wide  = ang_s - (ANG_RED_W+1)'(ANG_QUARTER);
        end else if (ang_s < ANG_EIGHTH + 2 * ANG_QUARTER) begin
            quad_next = QUAD_2;
            rem_wide  = ang_s - (ANG_RED_W+1)'(2 * ANG_QUARTER);
        end else if (ang_s < ANG_EIGHTH + 3 * ANG_QUARTER) begin
            quad_next = QUAD_3;
            rem_wide  = ang_s - (ANG_RED_W+1)'(3 * ANG_QUARTER);
        end else begin
            quad_next = QUAD_0;
            rem_wide  = ang_s - (ANG_RED_W+1)'(ANG_FULL);
        end
    end

    assign rem                 = rem_wide[REM_W-1:0];
    assign cside_next.geo      = s0_geo_reg;
    assign cside_next.quad     = quad_next;
    assign cside_next.rem_zero = (rem == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            cv_reg[0] <= s0_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0]    <= X_W'(CORDIC_GAIN_Q30);
            cy_reg[0]    <= '0;
            cz_reg[0]    <= Z_W'(signed'({rem, {ZFRAC_W{1'b0}}}));
            cside_reg[0] <= cside_next;
        end
    end

    // ---- CORDIC iterations, one per stage ----
    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [X_W-1:0] xs;
        logic signed [X_W-1:0] ys;
        logic signed [X_W-1:0] cx_next;
        logic signed [X_W-1:0] cy_next;
        logic signed [Z_W-1:0] cz_next;

        assign xs = cx_reg[i] >>> i;
        assign ys = cy_reg[i] >>> i;

        always_comb begin
            if (!cz_reg[i][Z_W-1]) begin
                cx_next = cx_reg[i] - ys;
                cy_next = cy_reg[i] + xs;
                cz_next = cz_reg[i] - atan_entry(i);
            end else begin
                cx_next = cx_reg[i] + ys;
                cy_next = cy_reg[i] - xs;
                cz_next = cz_reg[i] + atan_entry(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cv_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[i+1]    <= cx_next;
                cy_reg[i+1]    <= cy_next;
                cz_reg[i+1]    <= cz_next;
                cside_reg[i+1] <= cside_reg[i];
            end
        end
    end

    // ---- cosine and sine with the quarter turn applied ----
    always_comb begin
        if (cside_reg[N].rem_zero) begin
            c0 = CS_W'(ONE_Q15);
            s0 = '0;
        end else begin
            c0 = round_q15(cx_reg[N]);
            s0 = round_q15(cy_reg[N]);
        end
        unique case (cside_reg[N].quad)
            QUAD_1: begin
                cs_c_next = -s0;
                cs_s_next = c0;
            end
            QUAD_2: begin
                cs_c_next = -c0;
                cs_s_next = -s0;
            end
            QUAD_3: begin
                cs_c_next = s0;
                cs_s_next = -c0;
            end
            default: begin
                cs_c_next = c0;
                cs_s_next = s0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_v_reg <= 1'b0;
            m_v_reg  <= 1'b0;
            sm_v_reg <= 1'b0;
            rv_reg   <= 1'b0;
        end
        else if (adv)
        begin
            cs_v_reg <= cv_reg[N];
            m_v_reg  <= cs_v_reg;
            sm_v_reg <= m_v_reg;
            rv_reg   <= sm_v_reg;
        end
    end

    // ---- products, sums, truncation ----
    assign sm_x_next = (SW'(m_qx_reg) <<< Q15) + SW'(m_xc_reg) - SW'(m_ys_reg);
    assign sm_y_next = (SW'(m_qy_reg) <<< Q15) + SW'(m_xs_reg) + SW'(m_yc_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cs_c_reg   <= cs_c_next;
            cs_s_reg   <= cs_s_next;
            cs_geo_reg <= cside_reg[N].geo;

            m_xc_reg <= PW'(cs_geo_reg.dx) * PW'(cs_c_reg);
            m_ys_reg <= PW'(cs_geo_reg.dy) * PW'(cs_s_reg);
            m_xs_reg <= PW'(cs_geo_reg.dx) * PW'(cs_s_reg);
            m_yc_reg <= PW'(cs_geo_reg.dy) * PW'(cs_c_reg);
            m_qx_reg <= cs_geo_reg.qx;
            m_qy_reg <= cs_geo_reg.qy;

            sm_x_reg <= sm_x_next;
            sm_y_reg <= sm_y_next;

            rx_reg <= finish(sm_x_reg);
            ry_reg <= finish(sm_y_reg);
        end
    end

    assign rsp.valid     = rv_reg;
    assign rsp.rotated_x = rx_reg;
    assign rsp.rotated_y = ry_reg;

endmodule

`default_nettype wire

/* sv/prap_checker.sv */
// ---------------------------------------------------------------------------
// Point rotation port checker
// Watches the ports of the point rotation block: reset state, stall
// behavior and how the output stall reaches the input side.
// ---------------------------------------------------------------------------
`default_nettype none

`include "point_rotate_about_pivot_macros.svh"

module prap_checker
    import prap_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    req_valid,
    input wire logic                    req_ready,
    input wire logic                    rsp_valid,
    input wire logic                    rsp_ready,
    input wire logic signed [OUT_W-1:0] rsp_rotated_x,
    input wire logic signed [OUT_W-1:0] rsp_rotated_y
);

    `PRAP_ASSERT_RST(a_no_result_in_reset, !rst_n |-> !rsp_valid, "result valid in reset")

    `PRAP_ASSERT(a_result_holds, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rotated_x) && $stable(rsp_rotated_y), "stalled result changed")

    // A result that is not taken freezes the pipeline, so no item may enter.
    `PRAP_ASSERT(a_stall_blocks_input, rsp_valid && !rsp_ready |-> !req_ready, "item taken while the result is stalled")

    // With the output register empty the pipeline always moves.
    `PRAP_ASSERT(a_empty_accepts, !rsp_valid |-> req_ready, "input refused with an empty output")

    // Every edge either moves the pipeline or blocks the input.
    `PRAP_ASSERT(a_ready_matches_output, req_ready == (!rsp_valid || rsp_ready), "input ready does not follow the output side")

endmodule

bind point_rotate_about_pivot prap_checker u_prap_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_rotated_x (rsp.rotated_x),
    .rsp_rotated_y (rsp.rotated_y)
);

`default_nettype wire

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// Point rotation about a pivot: testbench
// Drives points, pivots and angles into the block over its request channel and
// checks every rotated point against a CORDIC model kept in the testbench. The
// run covers directed corner cases, random items under several idle patterns
// on both channels, and a long hold on the result side that backs up the block.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import prap_pkg::*;

    localparam int COORD_WIDTH     = 12;
    localparam int TRIG_ITERATIONS = 16;
    localparam int COORD_MAX       = (1 << (COORD_WIDTH - 1)) - 1;
    localparam int COORD_MIN       = -(1 << (COORD_WIDTH - 1));
    localparam int DRAIN_CYCLES    = TRIG_ITERATIONS + 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_ITEMS     = 340;
    localparam int MAX_PRINTED     = 60;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [ANGLE_W-1:0]     angle_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
    } rot_point_t;

    logic clk;
    logic rst_n;

    prap_req_if #(.COORD_WIDTH(COORD_WIDTH)) req ();
    prap_rsp_if                              rsp ();

    point_rotate_about_pivot #(
        .COORD_WIDTH     (COORD_WIDTH),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    rot_point_t expected_points[$];
    int         mismatches = 0;
    int         send_idle_pct;
    int         stall_pct;
    int         hold_requests;
    int         idle_cycles;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Model of the rotation
    // -----------------------------------------------------------------------

    // Arctangent of 2^-i in degrees scaled by 2^20.
    function automatic longint atan_step(input int idx);
        case (idx)
            0:  return 47185920;
            1:  return 27855475;
            2:  return 14718068;
            3:  return 7471121;
            4:  return 3750058;
            5:  return 1876857;
            6:  return 938658;
            7:  return 469357;
            8:  return 234682;
            9:  return 117342;
            10: return 58671;
            11: return 29335;
            12: return 14668;
            13: return 7334;
            14: return 3667;
            15: return 1833;
            16: return 917;
            17: return 458;
            18: return 229;
            19: return 115;
            20: return 57;
            21: return 29;
            22: return 14;
            23: return 7;
            default: return 0;
        endcase
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Adds the pivot to a Q15 sum, truncates toward zero and saturates.
    function automatic logic signed [OUT_W-1:0] trunc_sat(input longint pivot, input longint sum);
        longint v;
        longint r;
        v = pivot * ONE_Q15 + sum;
        if (v < 0)
            r = -((-v) >>> Q15);
        else
            r = v >>> Q15;
        r = clamp_to(r, OUT_MIN, OUT_MAX);
        return r[OUT_W-1:0];
    endfunction

    function automatic rot_point_t rotate_about(input coord_t px, input coord_t py,
                                                input coord_t qx, input coord_t qy,
                                                input angle_t ang);
        longint     a;
        longint     quad;
        longint     rem;
        longint     c0;
        longint     s0;
        longint     cs;
        longint     sn;
        longint     x;
        longint     y;
        longint     z;
        longint     xs;
        longint     ys;
        longint     lpx;
        longint     lpy;
        longint     lqx;
        longint     lqy;
        logic [1:0] qd;
        int         i;
        rot_point_t res;

        a = ang;
        a = ((a % ANG_FULL) + ANG_FULL) % ANG_FULL;
        quad = (a + ANG_EIGHTH) / ANG_QUARTER;
        rem = a - quad * ANG_QUARTER;
        qd = quad[1:0];

        if (rem == 0) begin
            c0 = ONE_Q15;
            s0 = 0;
        end
        else begin
            x = CORDIC_GAIN_Q30;
            y = 0;
            z = rem * 65536;
            for (i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_step(i);
                end
                else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_step(i);
                end
            end
            c0 = clamp_to((x + ROUND_HALF_Q15) >>> Q15, -ONE_Q15, ONE_Q15);
            s0 = clamp_to((y + ROUND_HALF_Q15) >>> Q15, -ONE_Q15, ONE_Q15);
        end

        // The quarter turn is applied exactly on top of the remainder.
        case (qd)
            QUAD_1:  begin cs = -s0; sn = c0;  end
            QUAD_2:  begin cs = -c0; sn = -s0; end
            QUAD_3:  begin cs = s0;  sn = -c0; end
            default: begin cs = c0;  sn = s0;  end
        endcase

        lpx = px;
        lpy = py;
        lqx = qx;
        lqy = qy;
        res.x = trunc_sat(lqx, (lpx - lqx) * cs - (lpy - lqy) * sn);
        res.y = trunc_sat(lqy, (lpx - lqx) * sn + (lpy - lqy) * cs);
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("tb_top mismatch: %s", msg);
        mismatches++;
    endtask

    always @(posedge clk) begin : check_results
        rot_point_t want;
        if (rst_n) begin
            // Each result leaves only after its item has passed every pipeline stage, so check before pushing.
            if (rsp.valid && rsp.ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("result (%0d, %0d) with no item outstanding",
                                              rsp.rotated_x, rsp.rotated_y));
                end
                else begin
                    want = expected_points.pop_front();
                    if (rsp.rotated_x !== want.x)
                        report_mismatch($sformatf("rotated_x %0d, expected %0d",
                                                  rsp.rotated_x, want.x));
                    if (rsp.rotated_y !== want.y)
                        report_mismatch($sformatf("rotated_y %0d, expected %0d",
                                                  rsp.rotated_y, want.y));
                end
            end
            if (req.valid && req.ready)
                expected_points.push_back(rotate_about(req.point_x, req.point_y,
                                                       req.pivot_x, req.pivot_y, req.angle));
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // The receiver stalls at random, and for a long stretch whenever the
    // hold request count moves.
    initial begin : drive_ready
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else begin
                rsp.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------

    // Leaves valid high after the handshake so that back-to-back items never
    // see valid lowered and raised in one step.
    task automatic send_point(input coord_t x, input coord_t y, input coord_t px,
                              input coord_t py, input angle_t ang);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.point_x <= x;
        req.point_y <= y;
        req.pivot_x <= px;
        req.pivot_y <= py;
        req.angle   <= ang;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    // The three vertices of a triangle turned about its second vertex.
    task automatic send_triangle(input coord_t ax, input coord_t ay, input coord_t bx,
                                 input coord_t by, input coord_t cx, input coord_t cy,
                                 input angle_t ang);
        send_point(ax, ay, bx, by, ang);
        send_point(bx, by, bx, by, ang);
        send_point(cx, cy, bx, by, ang);
    endtask

    function automatic coord_t random_coord();
        case ($urandom_range(11))
            0:       return coord_t'(COORD_MAX);
            1:       return coord_t'(COORD_MIN);
            2:       return coord_t'(0);
            3:       return coord_t'(-1);
            default: return coord_t'($urandom_range((1 << COORD_WIDTH) - 1));
        endcase
    endfunction

    function automatic angle_t random_angle();
        int a_i;
        case ($urandom_range(9))
            0, 1, 2, 3: a_i = int'($urandom_range((1 << ANGLE_W) - 1));
            4, 5, 6:    a_i = int'($urandom_range(2 * ANG_FULL)) - ANG_FULL;
            7:          a_i = (int'($urandom_range(10)) - 5) * ANG_QUARTER;
            // Just around the odd eighths, where the quarter turn changes.
            8:          a_i = (int'($urandom_range(9)) - 5) * ANG_QUARTER + ANG_EIGHTH
                              + int'($urandom_range(2)) - 1;
            default:    a_i = int'($urandom_range(6)) - 3;
        endcase
        return angle_t'(a_i);
    endfunction

    task automatic send_random_points(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(11) == 0) begin
                send_triangle(random_coord(), random_coord(), random_coord(),
                              random_coord(), random_coord(), random_coord(),
                              random_angle());
                sent += 3;
            end
            else begin
                send_point(random_coord(), random_coord(), random_coord(),
                           random_coord(), random_angle());
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct <= 0;
        // Every quarter turn, a full turn either way and the angle extremes.
        send_point(100, 50, 0, 0, 0);
        send_point(100, 50, 0, 0, ANG_QUARTER);
        send_point(100, 50, 0, 0, 2 * ANG_QUARTER);
        send_point(100, 50, 0, 0, 3 * ANG_QUARTER);
        send_point(100, 50, 0, 0, ANG_FULL);
        send_point(100, 50, 0, 0, -ANG_QUARTER);
        send_point(100, 50, 0, 0, -ANG_FULL);
        send_point(100, 50, 0, 0, ANG_EIGHTH);
        send_point(100, 50, 0, 0, ANG_EIGHTH - 1);
        send_point(100, 50, 0, 0, -ANG_EIGHTH);
        send_point(100, 50, 0, 0, 1);
        send_point(100, 50, 0, 0, -1);
        send_point(100, 50, 0, 0, (1 << (ANGLE_W - 1)) - 1);
        send_point(100, 50, 0, 0, -(1 << (ANGLE_W - 1)));
        // Coordinate extremes, giving the largest offsets from the pivot.
        send_point(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, ANG_EIGHTH);
        send_point(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 2 * ANG_QUARTER);
        send_point(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1000);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 333);
        send_point(COORD_MAX, 0, 0, 0, ANG_FULL - 1);
        // Small negative results must truncate toward zero.
        send_point(-1, -1, 0, 0, 2000);
        send_triangle(0, 0, 400, 0, 200, 346, 960);
    endtask

    task automatic test_random_phase(input int sender_idle, input int receiver_stall);
        send_idle_pct = sender_idle;
        stall_pct <= receiver_stall;
        send_random_points(PHASE_ITEMS);
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the pipeline fills and the request side has to stall.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        send_random_points(60);
    endtask

    initial begin
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.point_x   <= '0;
        req.point_y   <= '0;
        req.pivot_x   <= '0;
        req.pivot_y   <= '0;
        req.angle     <= '0;
        send_idle_pct = 0;
        stall_pct     <= 0;
        hold_requests <= 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0);
        test_random_phase(58, 0);
        test_random_phase(0, 58);
        test_random_phase(11, 11);
        test_backpressure();

        req.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+sv
sv/prap_pkg.sv
sv/prap_if.sv
sv/point_rotate_about_pivot.sv
sv/prap_checker.sv
tb/tb_top.sv
